// ----- src/rlm_pkg.sv -----
// ----------------------------------------------------------------------------
// rlm_pkg
// Shared types and codes for the resource lock manager.
// ----------------------------------------------------------------------------
package rlm_pkg;

  localparam int WHO_W = 4;   // requester id width
  localparam int RSEL_W = 2;  // resource index width on the ports
  localparam int VAL_W = 16;  // stored value width

  localparam logic CMD_REQUEST = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic KIND_GRANT = 1'b0;
  localparam logic KIND_DROP  = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;  // capture the request from the input ports
    logic exec;  // update the touched resource
  } rlm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic emit;  // the request in execution produces a result
  } rlm_status_t;

endpackage

// ----- src/rlm_ctrl.sv -----
// ----------------------------------------------------------------------------
// rlm_ctrl
// Two-state sequencer: capture a request, then execute it.
// ----------------------------------------------------------------------------
module rlm_ctrl import rlm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  rlm_status_t status,
  output rlm_cmd_t    cmd,
  output logic        busy,
  output logic        out_valid
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd.load  = 1'b0;
    cmd.exec  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.exec & status.emit;
    end
  end

  assign busy      = (state_r == ST_EXEC);
  assign out_valid = out_valid_r;

endmodule

// ----- src/rlm_dp.sv -----
// ----------------------------------------------------------------------------
// rlm_dp
// Per-resource flags, values, list counts and the wait list memory.
// ----------------------------------------------------------------------------
module rlm_dp import rlm_pkg::*; #(
  parameter int NUM_RESOURCES = 4,
  parameter int WAIT_DEPTH    = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rlm_cmd_t          cmd,
  output rlm_status_t       status,
  input  logic              in_command,
  input  logic [WHO_W-1:0]  in_requester,
  input  logic [RSEL_W-1:0] in_resource,
  input  logic [VAL_W-1:0]  in_new_value,
  output logic              out_kind,
  output logic [WHO_W-1:0]  out_grantee,
  output logic [RSEL_W-1:0] out_granted_resource,
  output logic [VAL_W-1:0]  out_resource_value
);

  localparam int RES_W = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
  localparam int IDX_W = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int CNT_W = $clog2(WAIT_DEPTH + 1);
  localparam int MEM_DEPTH = 2 ** (RES_W + IDX_W);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(WAIT_DEPTH);

  // resource state
  logic             free_r  [NUM_RESOURCES];
  logic [VAL_W-1:0] value_r [NUM_RESOURCES];
  logic [CNT_W-1:0] count_r [NUM_RESOURCES];

  // captured request
  logic              cmd_r;
  logic [WHO_W-1:0]  who_r;
  logic [RSEL_W-1:0] res_r;
  logic [RES_W-1:0]  idx_r;
  logic [VAL_W-1:0]  val_r;
  logic              inrange_r;

  // wait lists, one block of WAIT_DEPTH entries per resource
  logic [WHO_W-1:0]       wait_mem [MEM_DEPTH];
  logic [WHO_W-1:0]       top_r;
  logic [RES_W+IDX_W-1:0] rd_addr, wr_addr;
  logic                   we;

  // result payload
  logic              kind_r;
  logic [WHO_W-1:0]  grantee_r;
  logic [RSEL_W-1:0] gres_r;
  logic [VAL_W-1:0]  rval_r;

  logic             in_inrange;
  logic [RES_W-1:0] in_idx;
  logic [CNT_W-1:0] in_cnt_m1;

  logic             cur_free;
  logic [CNT_W-1:0] cur_cnt;
  logic             emit, kind_nxt, free_nxt, set_val;
  logic [WHO_W-1:0] grantee_nxt;
  logic [VAL_W-1:0] rval_nxt;
  logic [CNT_W-1:0] cnt_nxt;

  // top-of-list read issued from the ports so the data is ready in EXEC
  assign in_inrange = (32'(in_resource) < NUM_RESOURCES);
  assign in_idx     = in_inrange ? RES_W'(in_resource) : '0;
  assign in_cnt_m1  = count_r[in_idx] - CNT_W'(1);
  assign rd_addr    = {in_idx, in_cnt_m1[IDX_W-1:0]};

  assign cur_free = free_r[idx_r];
  assign cur_cnt  = count_r[idx_r];
  assign wr_addr  = {idx_r, cur_cnt[IDX_W-1:0]};

  always_comb begin
    emit        = 1'b0;
    kind_nxt    = KIND_GRANT;
    grantee_nxt = who_r;
    rval_nxt    = '0;
    free_nxt    = cur_free;
    cnt_nxt     = cur_cnt;
    set_val     = 1'b0;
    we          = 1'b0;
    if (cmd.exec && inrange_r) begin
      priority if (cmd_r == CMD_RELEASE) begin
        set_val = 1'b1;
        if (cur_cnt != '0) begin
          // hand over to the most recent waiter
          emit        = 1'b1;
          grantee_nxt = top_r;
          rval_nxt    = val_r;
          cnt_nxt     = cur_cnt - CNT_W'(1);
          free_nxt    = 1'b0;
        end else begin
          free_nxt = 1'b1;
        end
      end else if (cur_cnt >= FULL_CNT) begin
        emit     = 1'b1;
        kind_nxt = KIND_DROP;
      end else if (cur_free) begin
        // push then pop of the same entry: grant directly
        emit     = 1'b1;
        rval_nxt = value_r[idx_r];
        free_nxt = 1'b0;
      end else begin
        we      = 1'b1;
        cnt_nxt = cur_cnt + CNT_W'(1);
      end
    end
  end

  assign status.emit = emit;

  always_ff @(posedge clk) begin
    if (we) begin
      wait_mem[wr_addr] <= who_r;
    end
    top_r <= wait_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r     <= in_command;
      who_r     <= in_requester;
      res_r     <= in_resource;
      idx_r     <= in_idx;
      val_r     <= in_new_value;
      inrange_r <= in_inrange;
    end
    if (emit) begin
      kind_r    <= kind_nxt;
      grantee_r <= grantee_nxt;
      gres_r    <= res_r;
      rval_r    <= rval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_RESOURCES; i++) begin
        free_r[i]  <= 1'b1;
        value_r[i] <= '0;
        count_r[i] <= '0;
      end
    end else if (cmd.exec && inrange_r) begin
      free_r[idx_r]  <= free_nxt;
      count_r[idx_r] <= cnt_nxt;
      if (set_val) begin
        value_r[idx_r] <= val_r;
      end
    end
  end

  assign out_kind             = kind_r;
  assign out_grantee          = grantee_r;
  assign out_granted_resource = gres_r;
  assign out_resource_value   = rval_r;

`ifndef ASSERT_OFF
  // list count never passes the depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> cur_cnt <= FULL_CNT)
    else $error("wait count beyond depth");
  // a free resource never holds waiters
  a_free_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && inrange_r && cur_free) |-> cur_cnt == '0)
    else $error("free resource with waiters");
  // a drop reports a zero value
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && kind_nxt == KIND_DROP) |-> rval_nxt == '0)
    else $error("drop with nonzero value");
`endif

endmodule

// ----- src/resource_lock_manager.sv -----
// ----------------------------------------------------------------------------
// resource_lock_manager
// Lock manager with a LIFO wait list per resource; grants and overflow drops.
// ----------------------------------------------------------------------------
//  channel  | handshake                     | payload
//  ---------+-------------------------------+------------------------------------
//  request  | start & !busy                 | in_command, in_requester,
//           |                               | in_resource, in_new_value
//  result   | out_valid, one cycle, no stall| out_kind, out_grantee,
//           |                               | out_granted_resource,
//           |                               | out_resource_value
//
// Every request has a capture step (which also reads the top
// of the resource's wait list from the memory port) and an execute step
// that updates flag, count, value and list. busy is high in the execute cycle.
// A result, if any, shows on the out_ ports for one cycle right after execute,
// while the next request may already be accepted. The receiver cannot stall.
// Synchronous active-low reset frees every resource, zeroes values and empties
// all lists; list memory contents are not cleared, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module resource_lock_manager import rlm_pkg::*; #(
  parameter int NUM_RESOURCES = 4,
  parameter int WAIT_DEPTH    = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_command,
  input  logic [WHO_W-1:0]  in_requester,
  input  logic [RSEL_W-1:0] in_resource,
  input  logic [VAL_W-1:0]  in_new_value,
  output logic              out_valid,
  output logic              out_kind,
  output logic [WHO_W-1:0]  out_grantee,
  output logic [RSEL_W-1:0] out_granted_resource,
  output logic [VAL_W-1:0]  out_resource_value
);

  rlm_cmd_t    cmd;     // sequencer commands
  rlm_status_t status;  // result present in the execute cycle

  rlm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  rlm_dp #(
    .NUM_RESOURCES (NUM_RESOURCES),
    .WAIT_DEPTH    (WAIT_DEPTH)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (status),
    .in_command           (in_command),
    .in_requester         (in_requester),
    .in_resource          (in_resource),
    .in_new_value         (in_new_value),
    .out_kind             (out_kind),
    .out_grantee          (out_grantee),
    .out_granted_resource (out_granted_resource),
    .out_resource_value   (out_resource_value)
  );

`ifndef ASSERT_OFF
  // an accepted request always executes in the next cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request not executed");
  // busy drops again in the cycle after execute
  a_exec_once: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("busy longer than one cycle");
  // a result only follows an execute cycle
  a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without execute");
`endif

endmodule
